// File: sv/serial_bus_address_enumerator_core_assert.svh
// Assertion macros used by the checker of the enumerator.
// Each macro states one clocked property that is switched off while the
// synchronous reset is asserted.
`ifndef SERIAL_BUS_ADDRESS_ENUMERATOR_CORE_ASSERT_SVH
`define SERIAL_BUS_ADDRESS_ENUMERATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBAE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBAE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sbae_pkg.sv
package sbae_pkg;

    // Default number of bus addresses; address 0 is never probed.
    localparam int NUM_ADDRESSES_DEF = 16;

    // Item operations.
    localparam logic OP_START = 1'b0;
    localparam logic OP_REPLY = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_RESET   = 2'd0;
    localparam logic [1:0] KIND_COMMAND = 2'd1;
    localparam logic [1:0] KIND_REPORT  = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    // Bus command encoding.
    localparam logic [3:0] CMD_TALK_R3    = 4'hF;
    localparam logic [3:0] CMD_LISTEN_R3  = 4'hB;
    localparam logic [7:0] LISTEN_ADDR_OR = 8'h60;
    localparam logic [7:0] LISTEN_HANDLER = 8'hFE;
    localparam logic [1:0] LEN_TALK       = 2'd1;
    localparam logic [1:0] LEN_LISTEN     = 2'd3;

    typedef struct packed {
        logic       operation;
        logic [3:0] reply_length;
        logic [7:0] handler_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  command_length;
        logic [7:0]  command_byte0;
        logic [7:0]  command_byte1;
        logic [7:0]  command_byte2;
        logic        expect_reply;
        logic [3:0]  device_address;
        logic [3:0]  original_address_out;
        logic [7:0]  handler_id_out;
        logic [15:0] device_mask;
        logic        last;
    } t_result;

    function automatic t_result f_bus_reset(input logic last);
        t_result r;
        r      = '0;
        r.kind = KIND_RESET;
        r.last = last;
        return r;
    endfunction

    function automatic t_result f_talk(input logic [3:0] addr, input logic last);
        t_result r;
        r                = '0;
        r.kind           = KIND_COMMAND;
        r.command_length = LEN_TALK;
        r.command_byte0  = {addr, CMD_TALK_R3};
        r.expect_reply   = 1'b1;
        r.last           = last;
        return r;
    endfunction

    function automatic t_result f_listen(input logic [3:0] addr, input logic [3:0] to_addr,
                                         input logic last);
        t_result r;
        r                = '0;
        r.kind           = KIND_COMMAND;
        r.command_length = LEN_LISTEN;
        r.command_byte0  = {addr, CMD_LISTEN_R3};
        r.command_byte1  = {4'h0, to_addr} | LISTEN_ADDR_OR;
        r.command_byte2  = LISTEN_HANDLER;
        r.last           = last;
        return r;
    endfunction

    function automatic t_result f_report(input logic [3:0] addr, input logic [3:0] orig,
                                         input logic [7:0] hid, input logic last);
        t_result r;
        r                      = '0;
        r.kind                 = KIND_REPORT;
        r.device_address       = addr;
        r.original_address_out = orig;
        r.handler_id_out       = hid;
        r.last                 = last;
        return r;
    endfunction

    function automatic t_result f_scan_done(input logic [15:0] mask, input logic last);
        t_result r;
        r             = '0;
        r.kind        = KIND_DONE;
        r.device_mask = mask;
        r.last        = last;
        return r;
    endfunction

endpackage

// File: sv/serial_bus_address_enumerator_core.sv
// Channel   Direction  Handshake                        Payload
// item      in         i_item_valid / o_item_ready      i_item   (t_item)
// result    out        o_result_valid / i_result_ready  o_result (t_result)
//
// An item is taken when valid and ready are both high; every result then sits in the output register
// until its transfer completes, and the block takes no new item meanwhile.
// Searching the address table visits one address at a time, both for an occupied address and for
// the free address; the single read port of the address table sets this.
// Reset is synchronous and active low; it clears the table and the sequencer.
// A stalled result simply holds the block in its emit state.

module serial_bus_address_enumerator_core
    import sbae_pkg::*;
#(
    parameter int NUM_ADDRESSES = NUM_ADDRESSES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    output logic    o_item_ready,
    input  t_item   i_item,
    output logic    o_result_valid,
    input  logic    i_result_ready,
    output t_result o_result
);

    // Width of a table index, and of a search pointer that can also hold the table depth.
    localparam int AW = $clog2(NUM_ADDRESSES);
    localparam logic [AW:0] PTR_END = (AW + 1)'(NUM_ADDRESSES);
    localparam logic [AW:0] PTR_FIRST = (AW + 1)'(1);

    // Sequencer states: waiting for an item, presenting a result, walking the table for
    // the next occupied address, and walking down for the next free address.
    typedef enum logic [3:0] {
        SQ_IDLE = 4'b0001,
        SQ_EMIT = 4'b0010,
        SQ_SCAN = 4'b0100,
        SQ_FREE = 4'b1000
    } t_seq;

    // Scan phase: what the next reply item means.
    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_PROBE   = 5'b00010,
        PH_COLLIDE = 5'b00100,
        PH_TEST    = 5'b01000,
        PH_HANDLER = 5'b10000
    } t_phase;

    // What follows once the presented result has been transferred.
    typedef enum logic [1:0] {
        CONT_DONE = 2'd0,
        CONT_TALK = 2'd1,
        CONT_SCAN = 2'd2
    } t_cont;

    t_seq            r_seq, n_seq;
    t_phase          r_phase, n_phase;
    t_cont           r_cont, n_cont;
    logic [3:0]      r_origin [NUM_ADDRESSES];
    logic [AW-1:0]   r_cur, n_cur;
    logic [AW-1:0]   r_hf, n_hf;
    logic            r_moved, n_moved;
    logic [15:0]     r_mask, n_mask;
    logic [AW:0]     r_ptr, n_ptr;
    logic            r_scan_handler, n_scan_handler;
    t_result         r_out, n_out;

    // Table access: one read address and one write address per cycle, plus a clear on start.
    logic            tbl_clear;
    logic            tbl_wr_en;
    logic [AW-1:0]   tbl_wr_addr;
    logic [3:0]      tbl_wr_data;
    logic [AW-1:0]   tbl_rd_addr;
    logic [3:0]      tbl_rd_data;

    logic            accept;
    logic            answered;
    logic [AW:0]     cur_next;
    logic [AW-1:0]   probe_hf;

    assign o_item_ready   = (r_seq == SQ_IDLE);
    assign o_result_valid = (r_seq == SQ_EMIT);
    assign o_result       = r_out;

    assign accept   = i_item_valid && o_item_ready;
    // A reply of more than one byte means a device answered.
    assign answered = (i_item.reply_length > 4'd1);
    assign cur_next = {1'b0, r_cur} + PTR_FIRST;
    // During probing, the highest silent address becomes the free address.
    assign probe_hf = (!answered && (r_cur > r_hf)) ? r_cur : r_hf;

    always_comb begin
        unique case (r_seq)
            SQ_SCAN: tbl_rd_addr = r_ptr[AW-1:0];
            SQ_FREE: tbl_rd_addr = r_hf;
            default: tbl_rd_addr = r_cur;
        endcase
    end

    assign tbl_rd_data = r_origin[tbl_rd_addr];

    always_comb begin
        n_seq          = r_seq;
        n_phase        = r_phase;
        n_cont         = r_cont;
        n_cur          = r_cur;
        n_hf           = r_hf;
        n_moved        = r_moved;
        n_mask         = r_mask;
        n_ptr          = r_ptr;
        n_scan_handler = r_scan_handler;
        n_out          = r_out;
        tbl_clear      = 1'b0;
        tbl_wr_en      = 1'b0;
        tbl_wr_addr    = r_cur;
        tbl_wr_data    = 4'(r_cur);

        unique case (r_seq)
            SQ_IDLE: begin
                if (accept) begin
                    if (i_item.operation == OP_START) begin
                        // A start abandons any scan in progress and begins afresh.
                        tbl_clear = 1'b1;
                        n_hf      = '0;
                        n_moved   = 1'b0;
                        n_mask    = '0;
                        n_cur     = AW'(1);
                        n_phase   = PH_PROBE;
                        n_out     = f_bus_reset(1'b0);
                        n_cont    = CONT_TALK;
                        n_seq     = SQ_EMIT;
                    end else begin
                        unique case (r_phase)
                            PH_PROBE: begin
                                if (answered) begin
                                    tbl_wr_en = 1'b1;
                                end
                                n_hf = probe_hf;
                                if (cur_next < PTR_END) begin
                                    n_cur  = cur_next[AW-1:0];
                                    n_out  = f_talk(4'(cur_next[AW-1:0]), 1'b1);
                                    n_cont = CONT_DONE;
                                    n_seq  = SQ_EMIT;
                                end else begin
                                    // Resolution only runs if a free address exists.
                                    n_moved        = 1'b0;
                                    n_scan_handler = (probe_hf == '0);
                                    n_ptr          = PTR_FIRST;
                                    n_seq          = SQ_SCAN;
                                end
                            end
                            PH_COLLIDE: begin
                                // The reply to the collision talk carries nothing of use.
                                n_out   = f_listen(4'(r_cur), 4'(r_hf), 1'b0);
                                n_cont  = CONT_TALK;
                                n_phase = PH_TEST;
                                n_seq   = SQ_EMIT;
                            end
                            PH_TEST: begin
                                if (answered) begin
                                    // A device is still at the old address, so the moved
                                    // one stays at the free address.
                                    tbl_wr_en   = 1'b1;
                                    tbl_wr_addr = r_hf;
                                    tbl_wr_data = tbl_rd_data;
                                    n_seq       = SQ_FREE;
                                end else begin
                                    // Nobody left behind: move the device back.
                                    n_out          = f_listen(4'(r_hf), 4'(r_cur), 1'b0);
                                    n_cont         = CONT_SCAN;
                                    n_ptr          = cur_next;
                                    n_scan_handler = 1'b0;
                                    n_seq          = SQ_EMIT;
                                end
                            end
                            PH_HANDLER: begin
                                n_mask         = r_mask | (16'(1) << r_cur);
                                n_out          = f_report(4'(r_cur), tbl_rd_data,
                                                          i_item.handler_byte, 1'b0);
                                n_cont         = CONT_SCAN;
                                n_ptr          = cur_next;
                                n_scan_handler = 1'b1;
                                n_seq          = SQ_EMIT;
                            end
                            default: begin
                                // A reply with no scan in progress is dropped.
                            end
                        endcase
                    end
                end
            end
            SQ_EMIT: begin
                if (i_result_ready) begin
                    unique case (r_cont)
                        CONT_TALK: begin
                            n_out  = f_talk(4'(r_cur), 1'b1);
                            n_cont = CONT_DONE;
                        end
                        CONT_SCAN: begin
                            n_seq = SQ_SCAN;
                        end
                        default: begin
                            n_seq = SQ_IDLE;
                        end
                    endcase
                end
            end
            SQ_SCAN: begin
                if (r_ptr < PTR_END) begin
                    if (tbl_rd_data != 4'd0) begin
                        n_cur   = r_ptr[AW-1:0];
                        n_phase = r_scan_handler ? PH_HANDLER : PH_COLLIDE;
                        n_out   = f_talk(4'(r_ptr[AW-1:0]), 1'b1);
                        n_cont  = CONT_DONE;
                        n_seq   = SQ_EMIT;
                    end else begin
                        n_ptr = r_ptr + PTR_FIRST;
                    end
                end else if (!r_scan_handler && r_moved && (r_hf != '0)) begin
                    // The pass moved a device and space remains: run another pass.
                    n_moved = 1'b0;
                    n_ptr   = PTR_FIRST;
                end else if (!r_scan_handler) begin
                    n_scan_handler = 1'b1;
                    n_ptr          = PTR_FIRST;
                end else begin
                    n_phase = PH_IDLE;
                    n_out   = f_scan_done(r_mask, 1'b1);
                    n_cont  = CONT_DONE;
                    n_seq   = SQ_EMIT;
                end
            end
            SQ_FREE: begin
                if (r_hf == '0) begin
                    // Free addresses are exhausted; resolution stops at once.
                    n_scan_handler = 1'b1;
                    n_ptr          = PTR_FIRST;
                    n_seq          = SQ_SCAN;
                end else if (tbl_rd_data != 4'd0) begin
                    n_hf = r_hf - AW'(1);
                end else begin
                    n_moved        = 1'b1;
                    n_scan_handler = 1'b0;
                    n_ptr          = cur_next;
                    n_seq          = SQ_SCAN;
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq          <= SQ_IDLE;
            r_phase        <= PH_IDLE;
            r_cont         <= CONT_DONE;
            r_cur          <= '0;
            r_hf           <= '0;
            r_moved        <= 1'b0;
            r_mask         <= '0;
            r_ptr          <= '0;
            r_scan_handler <= 1'b0;
        end else begin
            r_seq          <= n_seq;
            r_phase        <= n_phase;
            r_cont         <= n_cont;
            r_cur          <= n_cur;
            r_hf           <= n_hf;
            r_moved        <= n_moved;
            r_mask         <= n_mask;
            r_ptr          <= n_ptr;
            r_scan_handler <= n_scan_handler;
        end
    end

    // The address table holds each device's original address; zero means unoccupied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || tbl_clear) begin
            for (int k = 0; k < NUM_ADDRESSES; k++) begin
                r_origin[k] <= 4'd0;
            end
        end else if (tbl_wr_en) begin
            r_origin[tbl_wr_addr] <= tbl_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// File: sv/sbae_checker.sv
`include "serial_bus_address_enumerator_core_assert.svh"

module sbae_checker
    import sbae_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    o_item_ready,
    input logic    o_result_valid,
    input logic    i_result_ready,
    input t_result o_result
);

    `SBAE_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_result_valid && !i_result_ready, o_result_valid, "result dropped before transfer")
    `SBAE_ASSERT_NEXT(a_result_stable, i_clk, i_rst_n, o_result_valid && !i_result_ready, $stable(o_result), "stalled result changed")
    `SBAE_ASSERT_SAME(a_busy_with_result, i_clk, i_rst_n, o_result_valid, !o_item_ready, "item taken while a result waits")
    `SBAE_ASSERT_NEXT(a_ready_after_last, i_clk, i_rst_n, o_result_valid && i_result_ready && o_result.last, o_item_ready && !o_result_valid, "not ready after the last result")
    `SBAE_ASSERT_SAME(a_reset_not_last, i_clk, i_rst_n, o_result_valid && (o_result.kind == KIND_RESET), !o_result.last, "bus reset marked as last result")

endmodule

bind serial_bus_address_enumerator_core sbae_checker u_sbae_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_item_ready   (o_item_ready),
    .o_result_valid (o_result_valid),
    .i_result_ready (i_result_ready),
    .o_result       (o_result)
);
